// ===== src/spectrum_peak_picker_core_assert.svh =====
// Assertion macros used by the peak picker core module.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SPECTRUM_PEAK_PICKER_CORE_ASSERT_SVH
`define SPECTRUM_PEAK_PICKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SPP_ASSERT(label, clk, rst, prop, msg)
`define SPP_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== src/spp_pkg.sv =====
// Package of the spectrum peak picker: defaults, register codes, types.
// Depends on nothing.
package spp_pkg;
   localparam int MAX_BINS_DEF   = 1024;
   localparam int MAX_PEAKS_DEF  = 64;
   localparam int POWER_BITS_DEF = 32;
   localparam int RELIEF_ONE     = 256;

   typedef enum logic [2:0] {
      REG_MIN_HEIGHT     = 3'd0,
      REG_PEAK_RADIUS    = 3'd1,
      REG_OUTSIDE_RADIUS = 3'd2,
      REG_INSIDE_RADIUS  = 3'd3,
      REG_MIN_RELIEF     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [31:0] height_floor;
      logic [8:0]  nbr_radius;
      logic [8:0]  outer_radius;
      logic [8:0]  inner_radius;
      logic [15:0] min_relief;
   } cfg_type;

   typedef enum logic [3:0] {
      B_IDLE, B_SETUP, B_DSIZE, B_MAXRD, B_CHECK, B_NBR, B_REL, B_NEXT,
      B_EMIT_RD, B_EMIT_WAIT, B_EMIT_OUT
   } back_state_type;
endpackage

// ===== src/spectrum_peak_picker_core.sv =====
// Bins are taken one per cycle while req_ready is high and stored, up to MAX_BINS of them,
// until the item marked last_bin; the block then scans the stored spectrum through the
// single read port of its bin memory and sends the peak indices in ascending order. The
// scan finds the block maxima, then tests each candidate's neighbourhood and, when the
// relief test runs, its relief; no bin of the next spectrum is taken until the last result
// has been delivered. There is no clearing pass after reset.
`include "spectrum_peak_picker_core_assert.svh"
module spectrum_peak_picker_core #(
   parameter int MAX_BINS   = spp_pkg::MAX_BINS_DEF,
   parameter int MAX_PEAKS  = spp_pkg::MAX_PEAKS_DEF,
   parameter int POWER_BITS = spp_pkg::POWER_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_bin_power,
   input  logic        req_last_bin,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_peak_index,
   output logic        rsp_found,
   output logic        rsp_truncated,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int IW = MAX_BINS > 1 ? $clog2(MAX_BINS) : 1;
   localparam int CW = $clog2(MAX_BINS+1);

   spp_pkg::cfg_type cfg_ff, cfg_in;
   logic             store_we;
   logic [IW-1:0]    store_waddr, store_raddr;
   logic [POWER_BITS-1:0] store_wdata, store_rdata;
   logic             cmd_push, cmd_full, cmd_pop, cmd_valid, scan_done, back_busy;
   logic [CW-1:0]    push_len, pop_len;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (spp_pkg::csr_index_type'(csr_index))
            spp_pkg::REG_MIN_HEIGHT:     cfg_in.height_floor = csr_wdata;
            spp_pkg::REG_PEAK_RADIUS:    cfg_in.nbr_radius   = csr_wdata[8:0];
            spp_pkg::REG_OUTSIDE_RADIUS: cfg_in.outer_radius = csr_wdata[8:0];
            spp_pkg::REG_INSIDE_RADIUS:  cfg_in.inner_radius = csr_wdata[8:0];
            spp_pkg::REG_MIN_RELIEF:     cfg_in.min_relief   = csr_wdata[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.height_floor <= '0;
         cfg_ff.nbr_radius   <= 9'd1;
         cfg_ff.outer_radius <= 9'd1;
         cfg_ff.inner_radius <= 9'd1;
         cfg_ff.min_relief   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spp_front #(.MAX_BINS(MAX_BINS), .POWER_BITS(POWER_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_bin_power (req_bin_power),
      .req_last_bin  (req_last_bin),
      .store_we      (store_we),
      .store_addr    (store_waddr),
      .store_data    (store_wdata),
      .cmd_push      (cmd_push),
      .cmd_len       (push_len),
      .cmd_full      (cmd_full),
      .scan_done     (scan_done)
   );

   spp_ram #(.WIDTH(POWER_BITS), .DEPTH(MAX_BINS)) u_bin_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (store_wdata),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

   spp_cmd_fifo #(.WIDTH(CW)) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_len),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .pop_data  (pop_len)
   );

   spp_back #(.MAX_BINS(MAX_BINS), .MAX_PEAKS(MAX_PEAKS), .POWER_BITS(POWER_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd_valid      (cmd_valid),
      .cmd_len        (pop_len),
      .cmd_pop        (cmd_pop),
      .store_raddr    (store_raddr),
      .store_rdata    (store_rdata),
      .scan_done      (scan_done),
      .busy           (back_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_peak_index (rsp_peak_index),
      .rsp_found      (rsp_found),
      .rsp_truncated  (rsp_truncated),
      .rsp_last       (rsp_last)
   );

   `SPP_ASSERT(a_load_idle, clock, reset, req_valid && req_ready |-> !back_busy, "bin in scan")
   `SPP_ASSERT(a_no_ready_in_emit, clock, reset, rsp_valid |-> !req_ready, "input open in emit")
   `SPP_ASSERT_NEVER(a_no_push_full, clock, reset, cmd_push && cmd_full, "scan queue overflow")
endmodule

// ===== src/spp_ram.sv =====
// Generic single write port, single read port memory with registered read.
// Depends on nothing.
module spp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/spp_cmd_fifo.sv =====
// Two-entry queue of spectrum lengths between the loader and the scanner.
// Depends on nothing.
module spp_cmd_fifo #(
   parameter int WIDTH = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule

// ===== src/spp_front.sv =====
// Loader: accepts bins, writes them to the bin memory and queues a scan.
// Depends on spp_pkg.
module spp_front #(
   parameter int MAX_BINS   = spp_pkg::MAX_BINS_DEF,
   parameter int POWER_BITS = spp_pkg::POWER_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [31:0]                                req_bin_power,
   input  logic                                       req_last_bin,
   output logic                                       store_we,
   output logic [(MAX_BINS > 1 ? $clog2(MAX_BINS) : 1)-1:0] store_addr,
   output logic [POWER_BITS-1:0]                      store_data,
   output logic                                       cmd_push,
   output logic [$clog2(MAX_BINS+1)-1:0]              cmd_len,
   input  logic                                       cmd_full,
   input  logic                                       scan_done
);
   localparam int IW = MAX_BINS > 1 ? $clog2(MAX_BINS) : 1;
   localparam int CW = $clog2(MAX_BINS+1);

   logic [CW-1:0] count_ff, count_in;
   logic          hold_ff, hold_in;
   logic          accept, room;

   assign req_ready  = !hold_ff && !cmd_full;
   assign accept     = req_valid && req_ready;
   assign room       = (count_ff < CW'(MAX_BINS));
   assign store_we   = accept && room;
   assign store_addr = count_ff[IW-1:0];
   assign store_data = POWER_BITS'(req_bin_power);
   assign cmd_push   = accept && req_last_bin;
   assign cmd_len    = room ? CW'(count_ff + 1'b1) : count_ff;

   always_comb begin
      count_in = count_ff;
      hold_in  = hold_ff;
      if (scan_done) begin
         hold_in = 1'b0;
      end
      if (accept) begin
         if (req_last_bin) begin
            count_in = '0;
            hold_in  = 1'b1;
         end else if (room) begin
            count_in = CW'(count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hold_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         hold_ff  <= hold_in;
      end
   end
endmodule

// ===== src/spp_back.sv =====
// Scanner: finds block maxima, tests neighbourhood and relief, lists and sends peaks.
// Depends on spp_pkg and spp_ram.
module spp_back #(
   parameter int MAX_BINS   = spp_pkg::MAX_BINS_DEF,
   parameter int MAX_PEAKS  = spp_pkg::MAX_PEAKS_DEF,
   parameter int POWER_BITS = spp_pkg::POWER_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  spp_pkg::cfg_type                           cfg,
   input  logic                                       cmd_valid,
   input  logic [$clog2(MAX_BINS+1)-1:0]              cmd_len,
   output logic                                       cmd_pop,
   output logic [(MAX_BINS > 1 ? $clog2(MAX_BINS) : 1)-1:0] store_raddr,
   input  logic [POWER_BITS-1:0]                      store_rdata,
   output logic                                       scan_done,
   output logic                                       busy,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [9:0]                                 rsp_peak_index,
   output logic                                       rsp_found,
   output logic                                       rsp_truncated,
   output logic                                       rsp_last
);
   localparam int IW = MAX_BINS > 1 ? $clog2(MAX_BINS) : 1;
   localparam int CW = $clog2(MAX_BINS+1);
   localparam int AW = CW + 2;
   localparam int PA = MAX_PEAKS > 1 ? $clog2(MAX_PEAKS) : 1;
   localparam int NW = $clog2(MAX_PEAKS+1);
   localparam int PW = POWER_BITS;
   localparam int HW = PW > 32 ? PW : 32;
   localparam int RW = PW + 16;

   spp_pkg::back_state_type state_ff, state_in;

   logic [AW-1:0] len_ff, len_in, rad_ff, rad_in, outr_ff, outr_in, inr_ff, inr_in;
   logic [AW-1:0] d_ff, d_in, base_ff, base_in, addr_ff, addr_in, stop_ff, stop_in;
   logic [AW-1:0] idx1_ff, idx1_in, idx2_ff, idx2_in, best_i_ff, best_i_in;
   logic          iss_ff, iss_in, v1_ff, v1_in, v2_ff, v2_in, ok_ff, ok_in;
   logic [RW-1:0] prod_ff, prod_in;
   logic [PW-1:0] best_v_ff, best_v_in;
   logic [NW-1:0] n_ff, n_in, e_ff, e_in;
   logic          trunc_ff, trunc_in;
   logic [9:0]    oidx_ff, oidx_in;
   logic          ofound_ff, ofound_in, otr_ff, otr_in, olast_ff, olast_in;

   logic [AW-1:0] lim, r_o, r_i, r_p, outr_c, inr_c, rad_c, nb, nb_end, nbr_dist;
   logic          sweep_done, cand_fail, use_rel, more_blocks;
   logic          pk_we;
   logic [IW-1:0] pk_rdata;

   spp_ram #(.WIDTH(IW), .DEPTH(MAX_PEAKS)) u_peak_ram (
      .clock (clock),
      .we    (pk_we),
      .waddr (n_ff[PA-1:0]),
      .wdata (best_i_ff[IW-1:0]),
      .raddr (e_ff[PA-1:0]),
      .rdata (pk_rdata)
   );

   always_comb begin
      lim    = (len_ff - 1'b1) >> 1;
      r_o    = (cfg.outer_radius == '0) ? AW'(1) : AW'(cfg.outer_radius);
      r_i    = (cfg.inner_radius == '0) ? AW'(1) : AW'(cfg.inner_radius);
      r_p    = (cfg.nbr_radius == '0) ? AW'(1) : AW'(cfg.nbr_radius);
      outr_c = (r_o > lim) ? lim : r_o;
      inr_c  = (r_i > outr_c) ? outr_c : r_i;
      rad_c  = (r_p < outr_c) ? outr_c : r_p;
      rad_c  = (rad_c > lim) ? lim : rad_c;
      nb     = base_ff + d_ff;
      nb_end = ((nb + d_ff) < len_ff) ? (nb + d_ff) : len_ff;
      more_blocks = (nb < len_ff);
      sweep_done  = !iss_ff && !v1_ff && !v2_ff;
      cand_fail   = (best_i_ff < rad_ff) || ((best_i_ff + rad_ff) >= len_ff)
                 || (HW'(best_v_ff) <= HW'(cfg.height_floor));
      use_rel     = ok_ff && (cfg.min_relief > 16'(spp_pkg::RELIEF_ONE))
                 && (outr_ff > inr_ff);
      nbr_dist    = (idx2_ff >= best_i_ff) ? (idx2_ff - best_i_ff)
                                           : (best_i_ff - idx2_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spp_pkg::B_IDLE:      if (cmd_valid) state_in = spp_pkg::B_SETUP;
         spp_pkg::B_SETUP:     state_in = spp_pkg::B_DSIZE;
         spp_pkg::B_DSIZE:     if ((d_ff << 1) > (rad_ff + 1'b1)) state_in = spp_pkg::B_MAXRD;
         spp_pkg::B_MAXRD:     if (sweep_done) state_in = spp_pkg::B_CHECK;
         spp_pkg::B_CHECK:     state_in = cand_fail ? spp_pkg::B_NEXT : spp_pkg::B_NBR;
         spp_pkg::B_NBR: begin
            if (sweep_done) state_in = use_rel ? spp_pkg::B_REL : spp_pkg::B_NEXT;
         end
         spp_pkg::B_REL:       if (sweep_done) state_in = spp_pkg::B_NEXT;
         spp_pkg::B_NEXT:      state_in = more_blocks ? spp_pkg::B_MAXRD : spp_pkg::B_EMIT_RD;
         spp_pkg::B_EMIT_RD: begin
            state_in = (n_ff == '0) ? spp_pkg::B_EMIT_OUT : spp_pkg::B_EMIT_WAIT;
         end
         spp_pkg::B_EMIT_WAIT: state_in = spp_pkg::B_EMIT_OUT;
         spp_pkg::B_EMIT_OUT: begin
            if (rsp_ready) state_in = olast_ff ? spp_pkg::B_IDLE : spp_pkg::B_EMIT_RD;
         end
         default:              state_in = spp_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop     = (state_ff == spp_pkg::B_IDLE) && cmd_valid;
      store_raddr = addr_ff[IW-1:0];
      busy        = (state_ff != spp_pkg::B_IDLE);
      rsp_valid   = (state_ff == spp_pkg::B_EMIT_OUT);
      scan_done   = rsp_valid && rsp_ready && olast_ff;
      pk_we       = (state_ff == spp_pkg::B_NEXT) && ok_ff && (n_ff < NW'(MAX_PEAKS));
      rsp_peak_index = oidx_ff;
      rsp_found      = ofound_ff;
      rsp_truncated  = otr_ff;
      rsp_last       = olast_ff;
   end

   always_comb begin
      len_in = len_ff;   rad_in = rad_ff;   outr_in = outr_ff;  inr_in = inr_ff;
      d_in = d_ff;       base_in = base_ff; addr_in = addr_ff;  stop_in = stop_ff;
      best_i_in = best_i_ff;  best_v_in = best_v_ff;  ok_in = ok_ff;
      n_in = n_ff;       e_in = e_ff;       trunc_in = trunc_ff;
      oidx_in = oidx_ff; ofound_in = ofound_ff; otr_in = otr_ff; olast_in = olast_ff;
      iss_in  = 1'b0;
      v1_in   = 1'b0;
      v2_in   = 1'b0;
      idx1_in = addr_ff;
      idx2_in = idx1_ff;
      prod_in = RW'(store_rdata) * RW'(cfg.min_relief);

      if (state_ff == spp_pkg::B_MAXRD || state_ff == spp_pkg::B_NBR
          || state_ff == spp_pkg::B_REL) begin
         iss_in  = iss_ff && (addr_ff != stop_ff);
         addr_in = iss_ff ? addr_ff + 1'b1 : addr_ff;
         v1_in   = iss_ff;
         v2_in   = v1_ff && (state_ff == spp_pkg::B_REL);
      end

      case (state_ff)
         spp_pkg::B_IDLE: begin
            len_in = AW'(cmd_len);
         end
         spp_pkg::B_SETUP: begin
            rad_in = rad_c;  outr_in = outr_c;  inr_in = inr_c;
            d_in = AW'(2);   base_in = '0;  n_in = '0;  trunc_in = 1'b0;
         end
         spp_pkg::B_DSIZE: begin
            if ((d_ff << 1) <= (rad_ff + 1'b1)) begin
               d_in = d_ff << 1;
            end else begin
               addr_in   = base_ff;
               stop_in   = ((base_ff + d_ff) < len_ff ? (base_ff + d_ff) : len_ff) - 1'b1;
               iss_in    = 1'b1;
               best_v_in = '0;
               best_i_in = base_ff;
            end
         end
         spp_pkg::B_MAXRD: begin
            if (v1_ff && store_rdata >= best_v_ff) begin
               best_v_in = store_rdata;
               best_i_in = idx1_ff;
            end
         end
         spp_pkg::B_CHECK: begin
            ok_in = !cand_fail;
            if (!cand_fail) begin
               addr_in = best_i_ff - rad_ff;
               stop_in = best_i_ff + rad_ff;
               iss_in  = 1'b1;
            end
         end
         spp_pkg::B_NBR: begin
            if (v1_ff && store_rdata > best_v_ff) begin
               ok_in = 1'b0;
            end
            if (sweep_done && use_rel) begin
               addr_in = best_i_ff - outr_ff;
               stop_in = best_i_ff + outr_ff;
               iss_in  = 1'b1;
            end
         end
         spp_pkg::B_REL: begin
            if (v2_ff && nbr_dist > inr_ff && RW'({best_v_ff, 8'h00}) < prod_ff) begin
               ok_in = 1'b0;
            end
         end
         spp_pkg::B_NEXT: begin
            if (ok_ff) begin
               if (n_ff < NW'(MAX_PEAKS)) begin
                  n_in = NW'(n_ff + 1'b1);
               end else begin
                  trunc_in = 1'b1;
               end
            end
            base_in   = nb;
            addr_in   = nb;
            stop_in   = nb_end - 1'b1;
            iss_in    = more_blocks;
            best_v_in = '0;
            best_i_in = nb;
            e_in      = '0;
         end
         spp_pkg::B_EMIT_RD: begin
            oidx_in   = '0;
            ofound_in = 1'b0;
            otr_in    = 1'b0;
            olast_in  = 1'b1;
         end
         spp_pkg::B_EMIT_WAIT: begin
            oidx_in   = 10'(pk_rdata);
            ofound_in = 1'b1;
            otr_in    = trunc_ff;
            olast_in  = (e_ff == NW'(n_ff - 1'b1));
         end
         spp_pkg::B_EMIT_OUT: begin
            if (rsp_ready) begin
               e_in = NW'(e_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spp_pkg::B_IDLE;
         iss_ff   <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         iss_ff   <= iss_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
      len_ff <= len_in;   rad_ff <= rad_in;   outr_ff <= outr_in;  inr_ff <= inr_in;
      d_ff <= d_in;       base_ff <= base_in; addr_ff <= addr_in;  stop_ff <= stop_in;
      idx1_ff <= idx1_in; idx2_ff <= idx2_in; prod_ff <= prod_in;
      best_i_ff <= best_i_in;  best_v_ff <= best_v_in;  ok_ff <= ok_in;
      n_ff <= n_in;       e_ff <= e_in;       trunc_ff <= trunc_in;
      oidx_ff <= oidx_in; ofound_ff <= ofound_in; otr_ff <= otr_in; olast_ff <= olast_in;
   end
endmodule
